/* rtl/c2dzb_pkg.sv */
package c2dzb_pkg;

	localparam int MAX_ROWS   = 64;
	localparam int MAX_COLS   = 64;
	localparam int MAX_KERNEL = 7;

	localparam int ROW_W  = 6;
	localparam int COL_W  = 6;
	localparam int VAL_W  = 16;
	localparam int DIM_W  = 7;
	localparam int KDIM_W = 3;
	localparam int PROD_W = 2 * VAL_W;
	localparam int SUM_W  = 37;
	localparam int ST_W   = 2;
	localparam int OP_W   = 2;
	localparam int CFG_IDX_W = 2;

	localparam int IMG_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int IMG_AW    = $clog2(IMG_DEPTH);
	localparam int KER_DEPTH = MAX_KERNEL * MAX_KERNEL;
	localparam int KER_AW    = $clog2(KER_DEPTH);

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 40;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [OP_W-1:0] OP_LOAD_KERNEL = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_IMAGE  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY       = 2'd2;

	localparam logic [ST_W-1:0] ST_INTERIOR = 2'd0;
	localparam logic [ST_W-1:0] ST_BORDER   = 2'd1;
	localparam logic [ST_W-1:0] ST_BAD_KER  = 2'd2;
	localparam logic [ST_W-1:0] ST_OUTSIDE  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS = 2'd3;

	typedef enum logic [1:0] {
		CMD_LOAD_KER,
		CMD_LOAD_IMG,
		CMD_QUERY
	} cmd_kind_t;

	// For a query, row and col hold the top left corner of the window.
	typedef struct packed {
		cmd_kind_t         kind;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [VAL_W-1:0]  value;
		logic [ST_W-1:0]   status;
		logic [KDIM_W-1:0] krows;
		logic [KDIM_W-1:0] kcols;
	} cmd_t;

endpackage

/* rtl/c2dzb_ram.sv */
module c2dzb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/c2dzb_fifo.sv */
module c2dzb_fifo import c2dzb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t               entry_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q;
	logic [FIFO_AW-1:0] rptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != FIFO_CW'(FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entry_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/c2dzb_front.sv */
module c2dzb_front import c2dzb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // row[5:0], col[11:6], value[27:12], zeros
	input  logic [OP_W-1:0]       s_tuser,   // operation
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DIM_W-1:0]      cfg_data,
	output logic                  push_valid,
	input  logic                  push_ready,
	output cmd_t                  push_cmd
);

	logic [DIM_W-1:0]  img_rows_q;
	logic [DIM_W-1:0]  img_cols_q;
	logic [KDIM_W-1:0] ker_rows_q;
	logic [KDIM_W-1:0] ker_cols_q;

	logic              item_v_q;
	logic [OP_W-1:0]   op_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [VAL_W-1:0]  val_q;

	logic [DIM_W-1:0]  rows_eff;
	logic [DIM_W-1:0]  cols_eff;
	logic [DIM_W-1:0]  kr7;
	logic [DIM_W-1:0]  kc7;
	logic [DIM_W-1:0]  hr7;
	logic [DIM_W-1:0]  hc7;
	logic [DIM_W-1:0]  r7;
	logic [DIM_W-1:0]  c7;
	logic              bad_kernel;
	logic              outside;
	logic              border;
	logic              keep;
	logic              consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_rows_q <= DIM_W'(64);
			img_cols_q <= DIM_W'(64);
			ker_rows_q <= KDIM_W'(3);
			ker_cols_q <= KDIM_W'(3);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_ROWS:  img_rows_q <= cfg_data;
				CFG_IMAGE_COLS:  img_cols_q <= cfg_data;
				CFG_KERNEL_ROWS: ker_rows_q <= cfg_data[KDIM_W-1:0];
				CFG_KERNEL_COLS: ker_cols_q <= cfg_data[KDIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_tready = !item_v_q || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_q <= 1'b0;
		end else if (s_tready) begin
			item_v_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= s_tuser;
			row_q <= s_tdata[ROW_W-1:0];
			col_q <= s_tdata[ROW_W+COL_W-1:ROW_W];
			val_q <= s_tdata[ROW_W+COL_W+VAL_W-1:ROW_W+COL_W];
		end
	end

	always_comb begin
		rows_eff = (img_rows_q > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : img_rows_q;
		cols_eff = (img_cols_q > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : img_cols_q;
		kr7 = DIM_W'(ker_rows_q);
		kc7 = DIM_W'(ker_cols_q);
		hr7 = DIM_W'((ker_rows_q - 1'b1) >> 1);
		hc7 = DIM_W'((ker_cols_q - 1'b1) >> 1);
		r7  = DIM_W'(row_q);
		c7  = DIM_W'(col_q);

		bad_kernel = !ker_rows_q[0] || (kr7 > DIM_W'(MAX_KERNEL)) || (kr7 > rows_eff) ||
			!ker_cols_q[0] || (kc7 > DIM_W'(MAX_KERNEL)) || (kc7 > cols_eff);
		outside = (r7 >= rows_eff) || (c7 >= cols_eff);
		border  = (r7 < hr7) || (r7 + hr7 >= rows_eff) ||
			(c7 < hc7) || (c7 + hc7 >= cols_eff);

		push_cmd.kind   = CMD_QUERY;
		push_cmd.row    = row_q;
		push_cmd.col    = col_q;
		push_cmd.value  = val_q;
		push_cmd.status = ST_INTERIOR;
		push_cmd.krows  = ker_rows_q;
		push_cmd.kcols  = ker_cols_q;
		keep = 1'b0;

		priority if (op_q == OP_LOAD_KERNEL) begin
			push_cmd.kind = CMD_LOAD_KER;
			keep = (r7 < DIM_W'(MAX_KERNEL)) && (c7 < DIM_W'(MAX_KERNEL));
		end else if (op_q == OP_LOAD_IMAGE) begin
			push_cmd.kind = CMD_LOAD_IMG;
			keep = (r7 < DIM_W'(MAX_ROWS)) && (c7 < DIM_W'(MAX_COLS));
		end else if (op_q == OP_QUERY) begin
			keep = 1'b1;
			push_cmd.row = row_q - ROW_W'(hr7);
			push_cmd.col = col_q - COL_W'(hc7);
			priority if (bad_kernel) begin
				push_cmd.status = ST_BAD_KER;
			end else if (outside) begin
				push_cmd.status = ST_OUTSIDE;
			end else if (border) begin
				push_cmd.status = ST_BORDER;
			end else begin
				push_cmd.status = ST_INTERIOR;
			end
		end else begin
			keep = 1'b0;
		end
	end

	assign push_valid = item_v_q && keep;
	assign consume    = item_v_q && (!keep || push_ready);

endmodule

/* rtl/c2dzb_back.sv */
module c2dzb_back import c2dzb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  cmd_t                  pop_cmd,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // pixel_sum[36:0], zeros
	output logic [ST_W-1:0]       m_tuser    // status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN
	} state_t;

	state_t                   state_q;
	logic [ROW_W-1:0]         base_r_q;
	logic [COL_W-1:0]         base_c_q;
	logic [KDIM_W-1:0]        krows_q;
	logic [KDIM_W-1:0]        kcols_q;
	logic [KDIM_W-1:0]        kr_q;
	logic [KDIM_W-1:0]        kc_q;
	logic signed [SUM_W-1:0]  acc_q;
	logic                     out_valid_q;
	logic [SUM_W-1:0]         out_sum_q;
	logic [ST_W-1:0]          out_status_q;

	logic                     tap_v_s1;
	logic                     last_s1;
	logic                     tap_v_s2;
	logic                     last_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic                     take;
	logic                     last_col;
	logic                     last_row;
	logic                     issue;
	logic                     img_we;
	logic                     ker_we;
	logic [IMG_AW-1:0]        img_waddr;
	logic [KER_AW-1:0]        ker_waddr;
	logic [IMG_AW-1:0]        img_raddr;
	logic [KER_AW-1:0]        ker_raddr;
	logic [VAL_W-1:0]         img_rd;
	logic [VAL_W-1:0]         ker_rd;
	logic signed [SUM_W-1:0]  prod_ext;

	assign pop_ready = (state_q == S_IDLE) && ((pop_cmd.kind != CMD_QUERY) || !out_valid_q);
	assign take      = pop_valid && pop_ready;
	assign issue     = (state_q == S_RUN);
	assign last_col  = (kc_q == kcols_q - 1'b1);
	assign last_row  = (kr_q == krows_q - 1'b1);

	assign img_we    = take && (pop_cmd.kind == CMD_LOAD_IMG);
	assign ker_we    = take && (pop_cmd.kind == CMD_LOAD_KER);
	assign img_waddr = IMG_AW'(pop_cmd.row) * IMG_AW'(MAX_COLS) + IMG_AW'(pop_cmd.col);
	assign ker_waddr = KER_AW'(pop_cmd.row) * KER_AW'(MAX_KERNEL) + KER_AW'(pop_cmd.col);
	assign img_raddr = IMG_AW'(base_r_q + ROW_W'(kr_q)) * IMG_AW'(MAX_COLS) +
		IMG_AW'(base_c_q + COL_W'(kc_q));
	assign ker_raddr = KER_AW'(kr_q) * KER_AW'(MAX_KERNEL) + KER_AW'(kc_q);

	c2dzb_ram #(.WIDTH(VAL_W), .DEPTH(IMG_DEPTH)) u_img_ram (
		.clk   (clk),
		.we    (img_we),
		.waddr (img_waddr),
		.wdata (pop_cmd.value),
		.raddr (img_raddr),
		.rdata (img_rd)
	);

	c2dzb_ram #(.WIDTH(VAL_W), .DEPTH(KER_DEPTH)) u_ker_ram (
		.clk   (clk),
		.we    (ker_we),
		.waddr (ker_waddr),
		.wdata (pop_cmd.value),
		.raddr (ker_raddr),
		.rdata (ker_rd)
	);

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(img_rd) * $signed(ker_rd);
	end

	assign prod_ext = {{(SUM_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			base_r_q     <= '0;
			base_c_q     <= '0;
			krows_q      <= '0;
			kcols_q      <= '0;
			kr_q         <= '0;
			kc_q         <= '0;
			acc_q        <= '0;
			out_valid_q  <= 1'b0;
			out_sum_q    <= '0;
			out_status_q <= ST_INTERIOR;
			tap_v_s1     <= 1'b0;
			last_s1      <= 1'b0;
			tap_v_s2     <= 1'b0;
			last_s2      <= 1'b0;
		end else begin
			tap_v_s1 <= issue;
			last_s1  <= issue && last_row && last_col;
			tap_v_s2 <= tap_v_s1;
			last_s2  <= last_s1;

			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end

			if (tap_v_s2) begin
				acc_q <= acc_q + prod_ext;
			end

			unique case (state_q)
				S_IDLE: begin
					if (take && (pop_cmd.kind == CMD_QUERY)) begin
						if (pop_cmd.status == ST_INTERIOR) begin
							state_q  <= S_RUN;
							base_r_q <= pop_cmd.row;
							base_c_q <= pop_cmd.col;
							krows_q  <= pop_cmd.krows;
							kcols_q  <= pop_cmd.kcols;
							kr_q     <= '0;
							kc_q     <= '0;
							acc_q    <= '0;
						end else begin
							out_valid_q  <= 1'b1;
							out_sum_q    <= '0;
							out_status_q <= pop_cmd.status;
						end
					end
				end
				S_RUN: begin
					if (last_col) begin
						kc_q <= '0;
						if (last_row) begin
							state_q <= S_DRAIN;
						end else begin
							kr_q <= kr_q + 1'b1;
						end
					end else begin
						kc_q <= kc_q + 1'b1;
					end
				end
				S_DRAIN: begin
					// The final tap leaves the multiplier; fold it in and publish.
					if (last_s2) begin
						state_q      <= S_IDLE;
						out_valid_q  <= 1'b1;
						out_sum_q    <= acc_q + prod_ext;
						out_status_q <= ST_INTERIOR;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'(out_sum_q);
	assign m_tuser  = out_status_q;

endmodule

/* rtl/conv2d_zero_border_top.sv */
// A load passes the front input register and the command FIFO and is written when the back
// end takes it; a query that ends in bad kernel, outside or border status loads the output
// register when taken. An interior query runs one multiply-accumulate per kernel tap
// on the shared multiplier. Loads go one per cycle while the back end is idle; a query
// waits for an empty output register, and an interior one holds the back end until done.
// Reset clears control state and sets the registers to 64, 64, 3, 3; stores are not cleared.
module conv2d_zero_border_top import c2dzb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // row[5:0], col[11:6], value[27:12], zeros
	input  logic [OP_W-1:0]       s_tuser,   // operation
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // pixel_sum[36:0], zeros
	output logic [ST_W-1:0]       m_tuser,   // status
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DIM_W-1:0]      cfg_data
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	c2dzb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	c2dzb_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	c2dzb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

/* bench/tb_top.sv */
module tb_top;
	import c2dzb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int ITEM_GOAL = 500;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 60;
	localparam int NUM_FIXED = 9;
	// image rows, image cols, kernel rows, kernel cols
	localparam int FIXED_CFG [NUM_FIXED][4] = '{
		'{7, 7, 7, 7},
		'{5, 6, 3, 1},
		'{1, 1, 1, 1},
		'{0, 3, 1, 1},
		'{127, 100, 5, 9},
		'{8, 8, 4, 3},
		'{3, 9, 5, 3},
		'{4, 4, 0, 1},
		'{64, 64, 7, 7}
	};

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [VAL_W-1:0] value;
	} conv_req_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [ST_W-1:0]  status;
	} conv_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [OP_W-1:0]       s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [ST_W-1:0]       m_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [DIM_W-1:0]      cfg_data = '0;

	conv2d_zero_border_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Register copies shared by the stimulus and the predictor; they change only while idle.
	logic [DIM_W-1:0]  img_rows_cfg = 7'd64;
	logic [DIM_W-1:0]  img_cols_cfg = 7'd64;
	logic [KDIM_W-1:0] ker_rows_cfg = 3'd3;
	logic [KDIM_W-1:0] ker_cols_cfg = 3'd3;

	logic [VAL_W-1:0] pix_mem [IMG_DEPTH];
	logic [VAL_W-1:0] ker_mem [KER_DEPTH];
	bit               pix_known [IMG_DEPTH];
	bit               ker_known [KER_DEPTH];

	conv_req_t    req_pending_q [$];
	conv_result_t conv_expected_q [$];
	conv_req_t    drv_req;
	conv_result_t want;

	int  idle_pct = 24;
	int  queued_total = 0;
	int  accepted_total = 0;
	int  item_cnt = 0;
	int  errors = 0;
	int  quiet_cycles = 0;
	bit  took = 1'b0;

	function automatic int eff_dim(logic [DIM_W-1:0] v, int lim);
		return (int'(v) > lim) ? lim : int'(v);
	endfunction

	function automatic logic [ST_W-1:0] classify(int r, int c);
		int rows, cols, kr, kc, hr, hc;
		rows = eff_dim(img_rows_cfg, MAX_ROWS);
		cols = eff_dim(img_cols_cfg, MAX_COLS);
		kr = int'(ker_rows_cfg);
		kc = int'(ker_cols_cfg);
		if (kr % 2 == 0 || kr > MAX_KERNEL || kr > rows || kc % 2 == 0 || kc > MAX_KERNEL ||
				kc > cols)
			return ST_BAD_KER;
		if (r >= rows || c >= cols)
			return ST_OUTSIDE;
		hr = (kr - 1) / 2;
		hc = (kc - 1) / 2;
		if (r < hr || r + hr >= rows || c < hc || c + hc >= cols)
			return ST_BORDER;
		return ST_INTERIOR;
	endfunction

	function automatic void conv_predict(logic [OP_W-1:0] op, int r, int c, logic [VAL_W-1:0] v);
		conv_result_t res;
		longint       acc;
		int           hr, hc;
		case (op)
			OP_LOAD_KERNEL: begin
				if (r < MAX_KERNEL && c < MAX_KERNEL)
					ker_mem[r * MAX_KERNEL + c] = v;
			end
			OP_LOAD_IMAGE: begin
				pix_mem[r * MAX_COLS + c] = v;
			end
			OP_QUERY: begin
				acc = 0;
				res.status = classify(r, c);
				if (res.status == ST_INTERIOR) begin
					hr = (int'(ker_rows_cfg) - 1) / 2;
					hc = (int'(ker_cols_cfg) - 1) / 2;
					for (int kr = 0; kr < int'(ker_rows_cfg); kr++)
						for (int kc = 0; kc < int'(ker_cols_cfg); kc++)
							acc += longint'($signed(pix_mem[(r - hr + kr) * MAX_COLS + c - hc + kc])) *
								longint'($signed(ker_mem[kr * MAX_KERNEL + kc]));
				end
				res.sum = acc[SUM_W-1:0];
				conv_expected_q.push_back(res);
			end
			default: ;
		endcase
	endfunction

	function automatic void push_req(logic [OP_W-1:0] op, int r, int c, logic [VAL_W-1:0] v);
		conv_req_t q;
		q.op = op;
		q.row = ROW_W'(r);
		q.col = COL_W'(c);
		q.value = v;
		req_pending_q.push_back(q);
		queued_total++;
		if (op == OP_LOAD_IMAGE) begin
			pix_known[r * MAX_COLS + c] = 1'b1;
			item_cnt++;
		end else if (op == OP_LOAD_KERNEL && r < MAX_KERNEL && c < MAX_KERNEL) begin
			ker_known[r * MAX_KERNEL + c] = 1'b1;
			item_cnt++;
		end else if (op == OP_QUERY) begin
			item_cnt++;
		end
	endfunction

	function automatic logic [VAL_W-1:0] rand_val();
		case ($urandom_range(19))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	// An interior query may only read entries that were written, so the missing ones go first.
	function automatic void fill_window(int r, int c);
		int hr, hc, pr, pc;
		hr = (int'(ker_rows_cfg) - 1) / 2;
		hc = (int'(ker_cols_cfg) - 1) / 2;
		for (int kr = 0; kr < int'(ker_rows_cfg); kr++)
			for (int kc = 0; kc < int'(ker_cols_cfg); kc++) begin
				pr = r - hr + kr;
				pc = c - hc + kc;
				if (!ker_known[kr * MAX_KERNEL + kc])
					push_req(OP_LOAD_KERNEL, kr, kc, rand_val());
				if (!pix_known[pr * MAX_COLS + pc])
					push_req(OP_LOAD_IMAGE, pr, pc, rand_val());
			end
	endfunction

	function automatic void random_action();
		int rows, cols, pick, r, c;
		rows = eff_dim(img_rows_cfg, MAX_ROWS);
		cols = eff_dim(img_cols_cfg, MAX_COLS);
		pick = $urandom_range(99);
		if (rows > 0 && cols > 0 && $urandom_range(9) < 8) begin
			r = $urandom_range(rows - 1);
			c = $urandom_range(cols - 1);
		end else begin
			r = $urandom_range(MAX_ROWS - 1);
			c = $urandom_range(MAX_COLS - 1);
		end
		if (pick < 55) begin
			if (classify(r, c) == ST_INTERIOR)
				fill_window(r, c);
			push_req(OP_QUERY, r, c, rand_val());
		end else if (pick < 92) begin
			push_req(OP_LOAD_IMAGE, r, c, rand_val());
		end else if (pick < 97) begin
			r = ($urandom_range(9) == 0) ? $urandom_range(MAX_ROWS - 1) : $urandom_range(MAX_KERNEL);
			c = ($urandom_range(9) == 0) ? $urandom_range(MAX_COLS - 1) : $urandom_range(MAX_KERNEL);
			push_req(OP_LOAD_KERNEL, r, c, rand_val());
		end else begin
			push_req(OP_UNUSED, r, c, rand_val());
		end
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= DIM_W'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_IMAGE_ROWS:  img_rows_cfg = DIM_W'(val);
			CFG_IMAGE_COLS:  img_cols_cfg = DIM_W'(val);
			CFG_KERNEL_ROWS: ker_rows_cfg = KDIM_W'(val);
			CFG_KERNEL_COLS: ker_cols_cfg = KDIM_W'(val);
			default: ;
		endcase
	endtask

	// Loads give no result, so a settle period follows the last one.
	task automatic wait_idle();
		while (accepted_total != queued_total || conv_expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || took)) begin
			if (req_pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				drv_req = req_pending_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= drv_req.op;
				s_tdata <= IN_DATA_W'({drv_req.value, drv_req.col, drv_req.row});
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			m_tready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		took = s_tvalid && s_tready;
		if (m_tvalid && m_tready) begin
			if (conv_expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with no request pending, expected none, actual sum %0d status %0d",
					$time, $signed(m_tdata[SUM_W-1:0]), m_tuser);
			end else begin
				want = conv_expected_q.pop_front();
				if (m_tuser !== want.status) begin
					errors++;
					$display("%0t: status expected %0d, actual %0d", $time, want.status, m_tuser);
				end
				if (m_tdata[SUM_W-1:0] !== want.sum) begin
					errors++;
					$display("%0t: pixel_sum expected %0d, actual %0d", $time, $signed(want.sum),
						$signed(m_tdata[SUM_W-1:0]));
				end
			end
		end
		if (took) begin
			conv_predict(s_tuser, int'(s_tdata[ROW_W-1:0]), int'(s_tdata[ROW_W +: COL_W]),
				s_tdata[ROW_W+COL_W +: VAL_W]);
			accepted_total++;
		end
		if (!arst_n || took || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("%0t: nothing accepted for %0d cycles", $time, STALL_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int ph, budget;
		int cfg_vals [4];
		logic [VAL_W-1:0] ker_dir [9];
		logic [VAL_W-1:0] pix_dir [9];
		ker_dir = '{16'h8000, 16'h7FFF, 16'h0100, 16'hFFFF, 16'h8000, 16'h0001, 16'h7FFF,
			16'hFF00, 16'h8000};
		pix_dir = '{16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 16'hFFFF, 16'h7FFF,
			16'h0080, 16'h8000};
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Extreme values on a 3x3 window at the reset settings, then border and ignored items.
		for (int i = 0; i < 9; i++) begin
			push_req(OP_LOAD_KERNEL, i / 3, i % 3, ker_dir[i]);
			push_req(OP_LOAD_IMAGE, i / 3, i % 3, pix_dir[i]);
		end
		push_req(OP_QUERY, 1, 1, 16'hFFFF);
		push_req(OP_QUERY, 0, 0, 16'h0000);
		push_req(OP_QUERY, 63, 63, 16'h8000);
		push_req(OP_QUERY, 0, 63, 16'h7FFF);
		push_req(OP_UNUSED, 63, 63, 16'hFFFF);
		push_req(OP_LOAD_KERNEL, 7, 3, 16'h1234);
		push_req(OP_LOAD_KERNEL, 63, 63, 16'h4321);
		wait_idle();

		ph = 0;
		while (item_cnt < ITEM_GOAL) begin
			if (ph < NUM_FIXED) begin
				for (int i = 0; i < 4; i++)
					cfg_vals[i] = FIXED_CFG[ph][i];
			end else begin
				for (int i = 0; i < 2; i++)
					case ($urandom_range(19))
						0, 1, 2:  cfg_vals[i] = $urandom_range(127, 64);
						3, 4, 5:  cfg_vals[i] = $urandom_range(64, 1);
						default: cfg_vals[i] = $urandom_range(12, 1);
					endcase
				for (int i = 2; i < 4; i++)
					cfg_vals[i] = ($urandom_range(19) < 17) ? 2 * $urandom_range(3) + 1 :
						$urandom_range(7);
			end
			write_reg(CFG_IMAGE_ROWS, cfg_vals[0]);
			write_reg(CFG_IMAGE_COLS, cfg_vals[1]);
			write_reg(CFG_KERNEL_ROWS, cfg_vals[2]);
			write_reg(CFG_KERNEL_COLS, cfg_vals[3]);
			idle_pct = (ph == 1 || ph == 10) ? 0 : 24;

			if (ph == 0) begin
				// Largest positive sum, then the most negative one, on a full 7x7 window.
				for (int i = 0; i < KER_DEPTH; i++) begin
					push_req(OP_LOAD_KERNEL, i / MAX_KERNEL, i % MAX_KERNEL, 16'h8000);
					push_req(OP_LOAD_IMAGE, i / MAX_KERNEL, i % MAX_KERNEL, 16'h8000);
				end
				push_req(OP_QUERY, 3, 3, 16'h0000);
				for (int i = 0; i < KER_DEPTH; i++)
					push_req(OP_LOAD_IMAGE, i / MAX_KERNEL, i % MAX_KERNEL, 16'h7FFF);
				push_req(OP_QUERY, 3, 3, 16'hFFFF);
			end

			budget = item_cnt + ((classify(0, 0) == ST_BAD_KER) ? 15 : 40);
			while (item_cnt < budget)
				random_action();
			wait_idle();
			ph++;
		end

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
